// ===== rtl/core/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg: shared types and constants
// Codes, request/response structs and state types for the IPv4 forwarding core.
// ----------------------------------------------------------------------------
package ifd_pkg;

    // Input item kinds (carried on s_axis_tuser)
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_HDR   = 2'd2;

    // Fixed header word positions
    localparam logic [4:0] POS_IHL    = 5'd0;
    localparam logic [4:0] POS_TTL    = 5'd4;
    localparam logic [4:0] POS_CKSUM  = 5'd5;
    localparam logic [4:0] POS_DST_HI = 5'd8;
    localparam logic [4:0] POS_DST_LO = 5'd9;
    localparam logic [4:0] POS_MAX    = 5'd31;

    // TTL sits in the high byte of word 4
    localparam logic [15:0] TTL_ONE_WORD = 16'h0100;

    typedef enum logic [1:0] {
        VERDICT_FORWARD  = 2'd0,
        VERDICT_LOCAL    = 2'd1,
        VERDICT_TTL_ERR  = 2'd2,
        VERDICT_NO_ROUTE = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        TBL_CLEAR,
        TBL_ADD,
        TBL_LOOKUP
    } t_tbl_op;

    typedef struct packed {
        logic        valid;
        t_tbl_op     op;
        logic [31:0] key;
        logic [31:0] hop;
    } t_tbl_req;

    typedef struct packed {
        logic        done;
        logic        hit;
        logic [31:0] hop;
    } t_tbl_rsp;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] hop;
    } t_route_ent;

    typedef enum logic [1:0] {
        TS_CLEAR,
        TS_IDLE,
        TS_SCAN
    } t_tbl_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_RESULT
    } t_top_state;

endpackage

// ===== rtl/core/ipv4_forward_decide_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_forward_decide_core: IPv4 forwarding decision engine
// Parses header words, looks the destination up in an exact-match route
// table and emits verdict, next hop, new TTL and recomputed checksum.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                  Payload
//  s_axis    in   s_axis_tvalid/tready       tuser=mode, tdata=dst/hop/word, tlast
//  m_axis    out  m_axis_tvalid/tready       tuser=verdict, tdata=hop/ttl/checksum
//  cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_data = local address
//
//  A header word without tlast only updates the packet state. A packet end without
//  lookup passes from the result state into the output register. Route add
//  and packet end with lookup hold the input while the table walks the route
//  memory one entry per cycle, stopping at a hit or at the last entry. Table
//  clear writes every entry, one per cycle; the same sweep runs after reset and
//  no beat is taken until it ends. A packet end holds the input until the
//  output register is free; configuration beats are always accepted.
module ipv4_forward_decide_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] route_destination, [63:32] route_next_hop, [79:64] header_word
    input  logic [79:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] next_hop, [39:32] new_ttl, [55:40] new_checksum
    output logic [55:0] m_axis_tdata,
    // [1:0] verdict
    output logic [1:0]  m_axis_tuser,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    ifd_pkg::t_top_state r_state;
    ifd_pkg::t_top_state n_state;

    // Configuration
    logic [31:0] r_local;

    // Packet state
    logic [4:0]  r_pos;
    logic [3:0]  r_ihl;
    logic [7:0]  r_ttl;
    logic [31:0] r_dest;
    logic [20:0] r_sum;

    // Decision held until the output register frees
    ifd_pkg::t_verdict r_verdict;
    logic [31:0]       r_hop;

    // Output register
    logic              r_out_valid;
    ifd_pkg::t_verdict r_out_verdict;
    logic [31:0]       r_out_hop;
    logic [7:0]        r_out_ttl;
    logic [15:0]       r_out_ck;

    ifd_pkg::t_tbl_req tbl_req;
    ifd_pkg::t_tbl_rsp tbl_rsp;
    logic              tbl_busy;

    logic        s_accept;
    logic        hdr_beat;
    logic        last_beat;
    logic        out_free;
    logic        out_load;
    logic        need_lookup;

    logic [15:0] word;
    logic [3:0]  n_ihl;
    logic [7:0]  n_ttl;
    logic [31:0] n_dest;
    logic [15:0] ck_add;
    logic        ck_take;
    logic [20:0] n_sum;
    logic [4:0]  n_pos;
    logic [16:0] fold1;
    logic [15:0] fold2;

    assign o_cfg_ready = 1'b1;

    ifd_route_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_route_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp),
        .o_busy  (tbl_busy)
    );

    // Header word capture at fixed positions; IHL only gates the checksum
    always_comb begin
        word    = s_axis_tdata[79:64];
        n_ihl   = (r_pos == ifd_pkg::POS_IHL) ? word[11:8] : r_ihl;
        n_ttl   = (r_pos == ifd_pkg::POS_TTL) ? word[15:8] : r_ttl;
        n_dest  = r_dest;
        if (r_pos == ifd_pkg::POS_DST_HI) begin
            n_dest = {word, r_dest[15:0]};
        end else if (r_pos == ifd_pkg::POS_DST_LO) begin
            n_dest = {r_dest[31:16], word};
        end
        // Sum word 4 with the TTL already decremented, skip the checksum word
        ck_add  = (r_pos == ifd_pkg::POS_TTL) ? (word - ifd_pkg::TTL_ONE_WORD) : word;
        ck_take = (r_pos < {n_ihl, 1'b0}) && (r_pos != ifd_pkg::POS_CKSUM);
        n_sum   = ck_take ? (r_sum + {5'd0, ck_add}) : r_sum;
        n_pos   = (r_pos == ifd_pkg::POS_MAX) ? r_pos : (r_pos + 5'd1);
    end

    // End-around carry fold; the second add cannot carry again
    always_comb begin
        fold1 = {1'b0, r_sum[15:0]} + {12'd0, r_sum[20:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
    end

    assign out_free    = !r_out_valid || m_axis_tready;
    assign s_accept    = s_axis_tvalid && s_axis_tready;
    assign hdr_beat    = s_accept && (s_axis_tuser == ifd_pkg::MODE_HDR);
    assign last_beat   = hdr_beat && s_axis_tlast;
    assign need_lookup = (n_ttl != 8'd0) && (n_dest != r_local);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ifd_pkg::ST_IDLE: begin
                if (last_beat) begin
                    n_state = need_lookup ? ifd_pkg::ST_WAIT : ifd_pkg::ST_RESULT;
                end
            end
            ifd_pkg::ST_WAIT: begin
                if (tbl_rsp.done) begin
                    n_state = ifd_pkg::ST_RESULT;
                end
            end
            ifd_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = ifd_pkg::ST_IDLE;
                end
            end
            default: n_state = ifd_pkg::ST_IDLE;
        endcase
    end

    // State outputs: input ready, table requests, output load
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        tbl_req       = '{valid: 1'b0, op: ifd_pkg::TBL_LOOKUP,
                          key: n_dest, hop: s_axis_tdata[63:32]};
        unique case (r_state)
            ifd_pkg::ST_IDLE: begin
                s_axis_tready = !tbl_busy;
                if (s_accept) begin
                    unique case (s_axis_tuser)
                        ifd_pkg::MODE_CLEAR: begin
                            tbl_req.valid = 1'b1;
                            tbl_req.op    = ifd_pkg::TBL_CLEAR;
                        end
                        ifd_pkg::MODE_ADD: begin
                            tbl_req.valid = 1'b1;
                            tbl_req.op    = ifd_pkg::TBL_ADD;
                            tbl_req.key   = s_axis_tdata[31:0];
                        end
                        ifd_pkg::MODE_HDR: begin
                            tbl_req.valid = s_axis_tlast && need_lookup;
                        end
                        default: tbl_req.valid = 1'b0;
                    endcase
                end
            end
            ifd_pkg::ST_WAIT: begin
                s_axis_tready = 1'b0;
            end
            ifd_pkg::ST_RESULT: begin
                out_load = out_free;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ifd_pkg::ST_IDLE;
            r_local     <= '0;
            r_pos       <= '0;
            r_ihl       <= '0;
            r_ttl       <= '0;
            r_dest      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_local <= i_cfg_data;
            end
            if (hdr_beat) begin
                r_pos  <= n_pos;
                r_ihl  <= n_ihl;
                r_ttl  <= n_ttl;
                r_dest <= n_dest;
                r_sum  <= n_sum;
            end else if (out_load) begin
                // Drop packet state once its result is committed
                r_pos  <= '0;
                r_ihl  <= '0;
                r_ttl  <= '0;
                r_dest <= '0;
                r_sum  <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Decision and output payload
    always_ff @(posedge i_clk) begin
        if (last_beat) begin
            r_hop <= '0;
            if (n_ttl == 8'd0) begin
                r_verdict <= ifd_pkg::VERDICT_TTL_ERR;
            end else if (n_dest == r_local) begin
                r_verdict <= ifd_pkg::VERDICT_LOCAL;
            end else begin
                r_verdict <= ifd_pkg::VERDICT_NO_ROUTE;
            end
        end
        if (r_state == ifd_pkg::ST_WAIT && tbl_rsp.done) begin
            r_verdict <= tbl_rsp.hit ? ifd_pkg::VERDICT_FORWARD : ifd_pkg::VERDICT_NO_ROUTE;
            r_hop     <= tbl_rsp.hit ? tbl_rsp.hop : 32'd0;
        end
        if (out_load) begin
            r_out_verdict <= r_verdict;
            if (r_verdict == ifd_pkg::VERDICT_FORWARD) begin
                r_out_hop <= r_hop;
                r_out_ttl <= r_ttl - 8'd1;
                r_out_ck  <= ~fold2;
            end else begin
                r_out_hop <= '0;
                r_out_ttl <= '0;
                r_out_ck  <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_verdict;
    assign m_axis_tdata  = {r_out_ck, r_out_ttl, r_out_hop};

`ifndef NO_ASSERTIONS
    // A new result only comes out of the result state
    a_load_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load || ($rose(r_out_valid))) |-> (r_state == ifd_pkg::ST_RESULT)
            || ($past(r_state) == ifd_pkg::ST_RESULT))
        else $error("result loaded outside result state");

    // A lookup request always parks the core waiting for the table
    a_lookup_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_req.valid && tbl_req.op == ifd_pkg::TBL_LOOKUP) |=>
            (r_state == ifd_pkg::ST_WAIT))
        else $error("lookup issued without wait state");

    // Only forwarded packets carry hop, TTL and checksum
    a_drop_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_verdict != ifd_pkg::VERDICT_FORWARD) |->
            (r_out_hop == 32'd0 && r_out_ttl == 8'd0 && r_out_ck == 16'd0))
        else $error("non-forward result with payload");

    // Packet state starts over after each committed result
    a_packet_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_pos == 5'd0 && r_sum == 21'd0 && r_ttl == 8'd0))
        else $error("packet state not cleared after result");
`endif

endmodule

// ===== rtl/core/ifd_route_table.sv =====
// ----------------------------------------------------------------------------
// ifd_route_table: exact-match route memory
// One synchronous memory of {valid, key, hop}; the clear sweep writes the entries
// one per cycle, add and lookup walk them one per cycle through the registered read port.
// ----------------------------------------------------------------------------
module ifd_route_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ifd_pkg::t_tbl_req i_req,
    output ifd_pkg::t_tbl_rsp o_rsp,
    output logic              o_busy
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    ifd_pkg::t_route_ent r_mem [TABLE_DEPTH];
    ifd_pkg::t_route_ent r_rd_data;

    ifd_pkg::t_tbl_state r_state;
    ifd_pkg::t_tbl_state n_state;

    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    logic          r_issued_all;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic          r_is_add;
    logic [31:0]   r_key;
    logic [31:0]   r_hop;

    logic          cmp_hit;
    logic          scan_done;
    logic          free_found;
    logic [IW-1:0] free_idx;

    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    ifd_pkg::t_route_ent wr_data;

    // Compare stage: data in r_rd_data belongs to r_cmp_idx
    always_comb begin
        cmp_hit    = r_cmp_vld && r_rd_data.valid && (r_rd_data.key == r_key);
        scan_done  = cmp_hit || (r_cmp_vld && (r_cmp_idx == LAST_IDX));
        free_found = r_free_found || (r_cmp_vld && !r_rd_data.valid);
        free_idx   = r_free_found ? r_free_idx : r_cmp_idx;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ifd_pkg::TS_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ifd_pkg::TS_IDLE;
                end
            end
            ifd_pkg::TS_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.op == ifd_pkg::TBL_CLEAR) ? ifd_pkg::TS_CLEAR
                                                                : ifd_pkg::TS_SCAN;
                end
            end
            ifd_pkg::TS_SCAN: begin
                if (scan_done) begin
                    n_state = ifd_pkg::TS_IDLE;
                end
            end
            default: n_state = ifd_pkg::TS_CLEAR;
        endcase
    end

    always_comb begin
        o_busy       = 1'b0;
        o_rsp.done   = 1'b0;
        o_rsp.hit    = cmp_hit;
        o_rsp.hop    = r_rd_data.hop;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = '0;
        unique case (r_state)
            ifd_pkg::TS_CLEAR: begin
                o_busy = 1'b1;
                wr_en  = 1'b1;
            end
            ifd_pkg::TS_IDLE: begin
                o_busy = 1'b0;
            end
            ifd_pkg::TS_SCAN: begin
                o_busy     = 1'b1;
                o_rsp.done = scan_done;
                wr_data    = '{valid: 1'b1, key: r_key, hop: r_hop};
                // Overwrite a matching key, else take the lowest free entry
                if (r_is_add && scan_done) begin
                    if (cmp_hit) begin
                        wr_en   = 1'b1;
                        wr_addr = r_cmp_idx;
                    end else if (free_found) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx;
                    end
                end
            end
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ifd_pkg::TS_CLEAR;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_issued_all <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ifd_pkg::TS_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                end
                ifd_pkg::TS_IDLE: begin
                    r_idx        <= '0;
                    r_cmp_vld    <= 1'b0;
                    r_issued_all <= 1'b0;
                    r_free_found <= 1'b0;
                end
                ifd_pkg::TS_SCAN: begin
                    r_free_found <= free_found;
                    if (!r_issued_all) begin
                        r_cmp_vld <= 1'b1;
                        if (r_idx == LAST_IDX) begin
                            r_issued_all <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                end
                default: r_idx <= '0;
            endcase
        end
    end

    // Payload side, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == ifd_pkg::TS_IDLE && i_req.valid) begin
            r_key    <= i_req.key;
            r_hop    <= i_req.hop;
            r_is_add <= (i_req.op == ifd_pkg::TBL_ADD);
        end
        if (r_state == ifd_pkg::TS_SCAN) begin
            r_cmp_idx  <= r_idx;
            r_free_idx <= free_idx;
        end
    end

endmodule
